// ===== design/spot_pkg.sv =====
// Shared types, codes, the quarter-wave sine table and the trig lookup for the overlap test.
package spot_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int TRIG_W = 18;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [15:0] QUARTER_TURN = 16'h4000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

	typedef enum logic [1:0] {KIND_EMPTY, KIND_RECT, KIND_CIRCLE} kind_t;
	typedef enum logic [1:0] {PC_EMPTY, PC_RECT_RECT, PC_CIRC_CIRC, PC_RECT_CIRC} pair_case_t;

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic [TRIG_W-1:0] sine_table_t [SINE_TABLE_DEPTH];

	typedef struct packed {
		logic [1:0] kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0] angle;
		logic [30:0] w;
		logic [30:0] h;
	} shape_t;

	typedef struct packed {
		shape_t a;
		shape_t b;
	} pair_t;

	// One classified pair: shape p is the rectangle of a mixed pair.
	typedef struct packed {
		pair_case_t pc;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [31:0] adx;
		logic [31:0] ady;
		logic [31:0] rs;
		logic [30:0] pw;
		logic [30:0] ph;
		logic [30:0] qw;
		logic [30:0] qh;
		trig_t cp;
		trig_t sp;
		trig_t cq;
		trig_t sq;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Nine-term Taylor series in Q30, evaluated once at elaboration.
	function automatic sine_table_t build_sine_table();
		sine_table_t tab;
		logic [63:0] x;
		logic [63:0] t;
		logic [63:0] plus;
		logic [63:0] minus;
		logic [63:0] s;
		for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
			t = x;
			plus = x;
			minus = '0;
			for (int k = 1; k <= 8; k++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / 64'((2 * k) * (2 * k + 1));
				if (k[0]) begin
					minus = minus + t;
				end else begin
					plus = plus + t;
				end
			end
			s = (plus > minus) ? plus - minus : '0;
			tab[i] = TRIG_W'((s + 64'd8192) >> 14);
		end
		return tab;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

	// Sine of a binary angle in Q.16, folded onto the quarter-wave table.
	function automatic trig_t sin_lookup(logic [15:0] ang);
		logic [14:0] u;
		logic [31:0] prod;
		logic [17:0] idx;
		trig_t m;
		u = ang[14] ? 15'(QUARTER_TURN) - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
		prod = 32'(u) * 32'(SINE_TABLE_DEPTH);
		idx = prod[31:14];
		if (idx >= 18'(SINE_TABLE_DEPTH)) begin
			m = TRIG_ONE;
		end else begin
			m = $signed(SINE_TABLE[idx[SINE_IDX_W-1:0]]);
		end
		return ang[15] ? -m : m;
	endfunction

endpackage

// ===== design/spot_front.sv =====
// Front end: takes a shape pair, classifies it, orders it and looks up its trig values.
module spot_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  spot_pkg::pair_t      pair_in,
	input  spot_pkg::queue_stat_t q_stat,
	output logic                 push,
	output spot_pkg::item_t      push_item
);

	logic             valid_s1;
	spot_pkg::pair_t  pair_s1;
	spot_pkg::shape_t p;
	spot_pkg::shape_t q;
	spot_pkg::pair_case_t pc;
	logic             swap;
	logic             accept;
	logic [32:0]      ndx;
	logic [32:0]      ndy;

	assign busy = valid_s1 && q_stat.full;
	assign accept = start && !busy;
	assign push = valid_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1 <= pair_in;
		end
	end

	always_comb begin
		pc = spot_pkg::PC_EMPTY;
		swap = 1'b0;
		case ({pair_s1.a.kind, pair_s1.b.kind})
			{spot_pkg::KIND_RECT, spot_pkg::KIND_RECT}: begin
				pc = spot_pkg::PC_RECT_RECT;
			end
			{spot_pkg::KIND_CIRCLE, spot_pkg::KIND_CIRCLE}: begin
				pc = spot_pkg::PC_CIRC_CIRC;
			end
			{spot_pkg::KIND_RECT, spot_pkg::KIND_CIRCLE}: begin
				pc = spot_pkg::PC_RECT_CIRC;
			end
			{spot_pkg::KIND_CIRCLE, spot_pkg::KIND_RECT}: begin
				pc = spot_pkg::PC_RECT_CIRC;
				swap = 1'b1;
			end
			default: begin
				pc = spot_pkg::PC_EMPTY;
			end
		endcase
	end

	always_comb begin
		p = swap ? pair_s1.b : pair_s1.a;
		q = swap ? pair_s1.a : pair_s1.b;
		push_item.pc = pc;
		push_item.dx = {p.x[31], p.x} - {q.x[31], q.x};
		push_item.dy = {p.y[31], p.y} - {q.y[31], q.y};
		ndx = -push_item.dx;
		ndy = -push_item.dy;
		push_item.adx = push_item.dx[32] ? ndx[31:0] : push_item.dx[31:0];
		push_item.ady = push_item.dy[32] ? ndy[31:0] : push_item.dy[31:0];
		push_item.rs = {1'b0, p.w} + {1'b0, q.w};
		push_item.pw = p.w;
		push_item.ph = p.h;
		push_item.qw = q.w;
		push_item.qh = q.h;
		push_item.cp = spot_pkg::sin_lookup(p.angle + spot_pkg::QUARTER_TURN);
		push_item.sp = spot_pkg::sin_lookup(p.angle);
		push_item.cq = spot_pkg::sin_lookup(q.angle + spot_pkg::QUARTER_TURN);
		push_item.sq = spot_pkg::sin_lookup(q.angle);
	end

endmodule

// ===== design/spot_queue.sv =====
// Short queue of classified pairs between the front end and the test pipeline.
module spot_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spot_pkg::item_t       push_item,
	input  logic                  pop,
	output spot_pkg::item_t       head,
	output spot_pkg::queue_stat_t stat
);

	spot_pkg::item_t entry_q [spot_pkg::QUEUE_DEPTH];
	logic [spot_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [spot_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [spot_pkg::QCNT_W-1:0] cnt_q;

	assign stat.full = (cnt_q == spot_pkg::QCNT_W'(spot_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head = entry_q[rd_ptr_q];

	function automatic logic [spot_pkg::QPTR_W-1:0] next_ptr(
		logic [spot_pkg::QPTR_W-1:0] ptr);
		if (ptr == spot_pkg::QPTR_W'(spot_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("transfer into a full queue");
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty)) else $error("queue count inconsistent");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !stat.empty) else $error("pushed entry lost");
`endif

endmodule

// ===== design/spot_back.sv =====
// Test pipeline: rectangle, circle and mixed overlap tests computed side by side.
module spot_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spot_pkg::queue_stat_t stat,
	input  spot_pkg::item_t       head,
	output logic                  pop,
	output logic                  done,
	output logic                  overlap,
	output spot_pkg::pair_case_t  pair_case
);

	typedef struct packed {
		logic [30:0] pw;
		logic [30:0] ph;
		logic [30:0] qw;
		logic [30:0] qh;
	} ext_t;

	// Stage 1: products.
	spot_pkg::trig_t nx [4];
	spot_pkg::trig_t ny [4];
	logic signed [50:0] pdx_s1 [4];
	logic signed [50:0] pdy_s1 [4];
	logic signed [35:0] mxx_s1 [4][4];
	logic signed [35:0] myy_s1 [4][4];
	logic [63:0] ccx_s1;
	logic [63:0] ccy_s1;
	logic [63:0] rs2_s1;
	ext_t g_s1;
	spot_pkg::pair_case_t pc_s1;
	logic v_s1;

	// Stage 2: sums.
	logic signed [51:0] pd_s2 [4];
	logic signed [36:0] ds_s2 [4][4];
	logic cc_s2;
	ext_t g_s2;
	spot_pkg::pair_case_t pc_s2;
	logic v_s2;

	// Stage 3: magnitudes and rounding.
	logic [52:0] proj_s3 [4];
	logic [20:0] dm_s3 [4][4];
	logic [36:0] ax_s3;
	logic [36:0] ay_s3;
	logic cc_s3;
	ext_t g_s3;
	spot_pkg::pair_case_t pc_s3;
	logic v_s3;

	// Stage 4: reach products and box-frame limits.
	logic [30:0] ext_w [4];
	logic [31:0] r2;
	logic [37:0] wr;
	logic [37:0] hr;
	logic [36:0] exd;
	logic [36:0] eyd;
	logic [51:0] rt_s4 [4][4];
	logic [52:0] proj_s4 [4];
	logic [31:0] ex_s4;
	logic [31:0] ey_s4;
	logic [31:0] r2_s4;
	logic far_s4;
	logic near_s4;
	logic cc_s4;
	spot_pkg::pair_case_t pc_s4;
	logic v_s4;

	// Stage 5: reach sums and corner squares.
	logic [53:0] reach_s5 [4];
	logic [52:0] proj_s5 [4];
	logic [63:0] exsq_s5;
	logic [63:0] eysq_s5;
	logic [63:0] r2sq_s5;
	logic far_s5;
	logic near_s5;
	logic cc_s5;
	spot_pkg::pair_case_t pc_s5;
	logic v_s5;

	// Final compares.
	logic rr_hit;
	logic corner;
	logic rc_hit;
	logic hit;
	logic overlap_q;
	spot_pkg::pair_case_t pair_case_q;
	logic done_q;

	function automatic logic [51:0] mag52(logic signed [51:0] v);
		return v[51] ? ~v + 52'd1 : v;
	endfunction

	// Magnitude rounded half up at bit 15; a negative value folds into one add.
	function automatic logic [36:0] round15(logic signed [51:0] v);
		logic [51:0] sum;
		sum = v[51] ? ~v + 52'd16385 : v + 52'd16384;
		return sum[51:15];
	endfunction

	function automatic logic [20:0] round16(logic signed [36:0] v);
		logic [36:0] sum;
		sum = v[36] ? ~v + 37'd32769 : v + 37'd32768;
		return sum[36:16];
	endfunction

	assign pop = !stat.empty;

	always_comb begin
		nx[0] = head.cp;
		ny[0] = head.sp;
		nx[1] = -head.sp;
		ny[1] = head.cp;
		nx[2] = head.cq;
		ny[2] = head.sq;
		nx[3] = -head.sq;
		ny[3] = head.cq;
	end

	always_comb begin
		ext_w[0] = g_s3.pw;
		ext_w[1] = g_s3.ph;
		ext_w[2] = g_s3.qw;
		ext_w[3] = g_s3.qh;
		r2 = {g_s3.qw, 1'b0};
		wr = 38'(g_s3.pw) + 38'(r2);
		hr = 38'(g_s3.ph) + 38'(r2);
		exd = ax_s3 - 37'(g_s3.pw);
		eyd = ay_s3 - 37'(g_s3.ph);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pdx_s1[i] <= 51'(head.dx) * 51'(nx[i]);
			pdy_s1[i] <= 51'(head.dy) * 51'(ny[i]);
			for (int j = 0; j < 4; j++) begin
				mxx_s1[i][j] <= 36'(nx[i]) * 36'(nx[j]);
				myy_s1[i][j] <= 36'(ny[i]) * 36'(ny[j]);
			end
		end
		ccx_s1 <= 64'(head.adx) * 64'(head.adx);
		ccy_s1 <= 64'(head.ady) * 64'(head.ady);
		rs2_s1 <= 64'(head.rs) * 64'(head.rs);
		g_s1 <= '{pw: head.pw, ph: head.ph, qw: head.qw, qh: head.qh};
		pc_s1 <= head.pc;

		for (int i = 0; i < 4; i++) begin
			pd_s2[i] <= 52'(pdx_s1[i]) + 52'(pdy_s1[i]);
			for (int j = 0; j < 4; j++) begin
				ds_s2[i][j] <= 37'(mxx_s1[i][j]) + 37'(myy_s1[i][j]);
			end
		end
		cc_s2 <= (65'(ccx_s1) + 65'(ccy_s1)) <= 65'(rs2_s1);
		g_s2 <= g_s1;
		pc_s2 <= pc_s1;

		for (int i = 0; i < 4; i++) begin
			proj_s3[i] <= {mag52(pd_s2[i]), 1'b0};
			for (int j = 0; j < 4; j++) begin
				dm_s3[i][j] <= round16(ds_s2[i][j]);
			end
		end
		ax_s3 <= round15(pd_s2[0]);
		ay_s3 <= round15(pd_s2[1]);
		cc_s3 <= cc_s2;
		g_s3 <= g_s2;
		pc_s3 <= pc_s2;

		for (int i = 0; i < 4; i++) begin
			proj_s4[i] <= proj_s3[i];
			for (int j = 0; j < 4; j++) begin
				rt_s4[i][j] <= 52'(ext_w[j]) * 52'(dm_s3[i][j]);
			end
		end
		// The corner offsets only matter when they are bounded by 2r, so 32 bits hold them.
		ex_s4 <= exd[31:0];
		ey_s4 <= eyd[31:0];
		r2_s4 <= r2;
		far_s4 <= (38'(ax_s3) > wr) || (38'(ay_s3) > hr);
		near_s4 <= (ax_s3 <= 37'(g_s3.pw)) || (ay_s3 <= 37'(g_s3.ph));
		cc_s4 <= cc_s3;
		pc_s4 <= pc_s3;

		for (int i = 0; i < 4; i++) begin
			reach_s5[i] <= 54'(rt_s4[i][0]) + 54'(rt_s4[i][1])
				+ 54'(rt_s4[i][2]) + 54'(rt_s4[i][3]);
			proj_s5[i] <= proj_s4[i];
		end
		exsq_s5 <= 64'(ex_s4) * 64'(ex_s4);
		eysq_s5 <= 64'(ey_s4) * 64'(ey_s4);
		r2sq_s5 <= 64'(r2_s4) * 64'(r2_s4);
		far_s5 <= far_s4;
		near_s5 <= near_s4;
		cc_s5 <= cc_s4;
		pc_s5 <= pc_s4;

		overlap_q <= hit;
		pair_case_q <= pc_s5;
	end

	always_comb begin
		rr_hit = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (54'(proj_s5[i]) > reach_s5[i]) begin
				rr_hit = 1'b0;
			end
		end
		corner = (65'(exsq_s5) + 65'(eysq_s5)) <= 65'(r2sq_s5);
		rc_hit = !far_s5 && (near_s5 || corner);
		case (pc_s5)
			spot_pkg::PC_RECT_RECT: hit = rr_hit;
			spot_pkg::PC_CIRC_CIRC: hit = cc_s5;
			spot_pkg::PC_RECT_CIRC: hit = rc_hit;
			default: hit = 1'b0;
		endcase
	end

	assign done = done_q;
	assign overlap = overlap_q;
	assign pair_case = pair_case_q;

`ifndef SYNTHESIS
	a_empty_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && pair_case_q == spot_pkg::PC_EMPTY |-> !overlap_q)
		else $error("overlap reported for an empty pair");
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |=> done_q) else $error("result dropped at the output stage");
`endif

endmodule

// ===== design/shape_pair_overlap_test.sv =====
// Top level of the shape pair overlap test: front end, queue and test pipeline.
//
//   channel   handshake              payload
//   input     start / busy           kind, pos_x, pos_y, angle, size_w, size_h of a and b
//   result    done (one-cycle pulse) overlap, pair_case
//
// A pair is taken at each edge with start high and busy low, one per cycle sustained.
// Its result is put out with done high after the queue and pipeline stages s1 to s5.
// The test pipeline never stalls, so busy stays low in steady operation.
// Reset clears only control state; the sine table is constant and needs no clearing pass.
module shape_pair_overlap_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind_a,
	input  logic signed [31:0] pos_x_a,
	input  logic signed [31:0] pos_y_a,
	input  logic [15:0]        angle_a,
	input  logic [30:0]        size_w_a,
	input  logic [30:0]        size_h_a,
	input  logic [1:0]         kind_b,
	input  logic signed [31:0] pos_x_b,
	input  logic signed [31:0] pos_y_b,
	input  logic [15:0]        angle_b,
	input  logic [30:0]        size_w_b,
	input  logic [30:0]        size_h_b,
	output logic               done,
	output logic               overlap,
	output logic [1:0]         pair_case
);

	spot_pkg::pair_t       pair_in;
	spot_pkg::queue_stat_t q_stat;
	spot_pkg::item_t       push_item;
	spot_pkg::item_t       head;
	spot_pkg::pair_case_t  pc_out;
	logic                  push;
	logic                  pop;

	assign pair_in.a = '{kind: kind_a, x: pos_x_a, y: pos_y_a, angle: angle_a,
		w: size_w_a, h: size_h_a};
	assign pair_in.b = '{kind: kind_b, x: pos_x_b, y: pos_y_b, angle: angle_b,
		w: size_w_b, h: size_h_b};

	spot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pair_in   (pair_in),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	spot_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	spot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.stat      (q_stat),
		.head      (head),
		.pop       (pop),
		.done      (done),
		.overlap   (overlap),
		.pair_case (pc_out)
	);

	assign pair_case = pc_out;

endmodule

// ===== sim/shape_pair_overlap_test_tb.sv =====
// Testbench for the shape pair overlap test: random and directed shape pairs checked by a scoreboard.
`timescale 1ns / 1ps

module shape_pair_overlap_test_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int N_RANDOM = 1880;
	localparam int DRAIN_CYCLES = 20;

	typedef longint unsigned u64_t;

	class overlap_board;
		typedef struct {
			bit hit;
			logic [1:0] pc;
		} verdict_t;

		verdict_t pending[$];
		int errors;
		u64_t quarter_sine[spot_pkg::SINE_TABLE_DEPTH];

		function new();
			u64_t x, t, plus, minus, s;
			errors = 0;
			for (int i = 0; i < spot_pkg::SINE_TABLE_DEPTH; i++) begin
				x = (u64_t'(1686629713) * u64_t'(i)) / spot_pkg::SINE_TABLE_DEPTH;
				t = x;
				plus = x;
				minus = 0;
				for (int k = 1; k <= 8; k++) begin
					t = (t * x) >> 30;
					t = (t * x) >> 30;
					t = t / u64_t'((2 * k) * (2 * k + 1));
					if (k % 2 == 1) begin
						minus += t;
					end else begin
						plus += t;
					end
				end
				s = (plus > minus) ? plus - minus : 0;
				quarter_sine[i] = ((s + 8192) >> 14) & 64'h3FFFF;
			end
		endfunction

		function longint quarter_lookup(int unsigned u);
			int unsigned idx;
			idx = (u * spot_pkg::SINE_TABLE_DEPTH) >> 14;
			if (idx >= spot_pkg::SINE_TABLE_DEPTH) return 65536;
			return longint'(quarter_sine[idx]);
		endfunction

		function longint sine_of(int unsigned ang);
			int unsigned q, f;
			longint m;
			ang = ang & 32'hFFFF;
			q = ang >> 14;
			f = ang & 32'h3FFF;
			m = q[0] ? quarter_lookup(16384 - f) : quarter_lookup(f);
			return q[1] ? -m : m;
		endfunction

		function longint cosine_of(int unsigned ang);
			return sine_of(ang + 16384);
		endfunction

		function u64_t magnitude(longint v);
			return (v < 0) ? u64_t'(-v) : u64_t'(v);
		endfunction

		function u64_t round_mag(longint v, int sh);
			return (magnitude(v) + (u64_t'(1) << (sh - 1))) >> sh;
		endfunction

		// Sum compare that treats a carry out of 64 bits as "too large".
		function bit sum_fits(u64_t a, u64_t b, u64_t c);
			u64_t s;
			s = a + b;
			if (s < a) return 0;
			return s <= c;
		endfunction

		function bit boxes_touch(spot_pkg::shape_t a, spot_pkg::shape_t b);
			longint axis[4][2];
			u64_t ext[4];
			longint dx, dy, nx, ny;
			u64_t proj, reach;
			axis[0][0] = cosine_of(a.angle);  axis[0][1] = sine_of(a.angle);
			axis[1][0] = -sine_of(a.angle);   axis[1][1] = cosine_of(a.angle);
			axis[2][0] = cosine_of(b.angle);  axis[2][1] = sine_of(b.angle);
			axis[3][0] = -sine_of(b.angle);   axis[3][1] = cosine_of(b.angle);
			ext[0] = u64_t'(a.w); ext[1] = u64_t'(a.h);
			ext[2] = u64_t'(b.w); ext[3] = u64_t'(b.h);
			dx = longint'($signed(b.x)) - longint'($signed(a.x));
			dy = longint'($signed(b.y)) - longint'($signed(a.y));
			for (int i = 0; i < 4; i++) begin
				nx = axis[i][0];
				ny = axis[i][1];
				proj = 2 * magnitude(dx * nx + dy * ny);
				reach = 0;
				for (int j = 0; j < 4; j++)
					reach += ext[j] * round_mag(axis[j][0] * nx + axis[j][1] * ny, 16);
				if (proj > reach) return 0;
			end
			return 1;
		endfunction

		function bit circles_touch(spot_pkg::shape_t a, spot_pkg::shape_t b);
			u64_t dx, dy, rs;
			dx = magnitude(longint'($signed(a.x)) - longint'($signed(b.x)));
			dy = magnitude(longint'($signed(a.y)) - longint'($signed(b.y)));
			rs = u64_t'(a.w) + u64_t'(b.w);
			return sum_fits(dx * dx, dy * dy, rs * rs);
		endfunction

		// Offset and sizes are all doubled here, so the radius enters as 2r.
		function bit box_circle_touch(spot_pkg::shape_t r, spot_pkg::shape_t c);
			longint cr, sr, dx, dy;
			u64_t ax, ay, r2, ex, ey, rw, rh;
			cr = cosine_of(r.angle);
			sr = sine_of(r.angle);
			dx = longint'($signed(r.x)) - longint'($signed(c.x));
			dy = longint'($signed(r.y)) - longint'($signed(c.y));
			ax = round_mag(dx * cr + dy * sr, 15);
			ay = round_mag(dy * cr - dx * sr, 15);
			r2 = 2 * u64_t'(c.w);
			rw = u64_t'(r.w);
			rh = u64_t'(r.h);
			if (ax > rw + r2) return 0;
			if (ay > rh + r2) return 0;
			if (ax <= rw) return 1;
			if (ay <= rh) return 1;
			ex = ax - rw;
			ey = ay - rh;
			return sum_fits(ex * ex, ey * ey, r2 * r2);
		endfunction

		function void note_transfer(spot_pkg::shape_t a, spot_pkg::shape_t b);
			verdict_t v;
			v.hit = 0;
			v.pc = spot_pkg::PC_EMPTY;
			if (a.kind == spot_pkg::KIND_RECT && b.kind == spot_pkg::KIND_RECT) begin
				v.pc = spot_pkg::PC_RECT_RECT;
				v.hit = boxes_touch(a, b);
			end else if (a.kind == spot_pkg::KIND_CIRCLE && b.kind == spot_pkg::KIND_CIRCLE) begin
				v.pc = spot_pkg::PC_CIRC_CIRC;
				v.hit = circles_touch(a, b);
			end else if (a.kind == spot_pkg::KIND_RECT && b.kind == spot_pkg::KIND_CIRCLE) begin
				v.pc = spot_pkg::PC_RECT_CIRC;
				v.hit = box_circle_touch(a, b);
			end else if (a.kind == spot_pkg::KIND_CIRCLE && b.kind == spot_pkg::KIND_RECT) begin
				v.pc = spot_pkg::PC_RECT_CIRC;
				v.hit = box_circle_touch(b, a);
			end
			pending.push_back(v);
		endfunction

		function void check_result(logic hit, logic [1:0] pc);
			verdict_t v;
			if (pending.size() == 0) begin
				$error("unexpected result: overlap %0d pair_case %0d", hit, pc);
				errors++;
				return;
			end
			v = pending.pop_front();
			if (hit !== v.hit) begin
				$error("overlap: expected %0d, actual %0d", v.hit, hit);
				errors++;
			end
			if (pc !== v.pc) begin
				$error("pair_case: expected %0d, actual %0d", v.pc, pc);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] kind_a, kind_b;
	logic signed [31:0] pos_x_a, pos_y_a, pos_x_b, pos_y_b;
	logic [15:0] angle_a, angle_b;
	logic [30:0] size_w_a, size_h_a, size_w_b, size_h_b;
	logic done;
	logic overlap;
	logic [1:0] pair_case;

	overlap_board board;

	shape_pair_overlap_test i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind_a(kind_a), .pos_x_a(pos_x_a), .pos_y_a(pos_y_a), .angle_a(angle_a),
		.size_w_a(size_w_a), .size_h_a(size_h_a),
		.kind_b(kind_b), .pos_x_b(pos_x_b), .pos_y_b(pos_y_b), .angle_b(angle_b),
		.size_w_b(size_w_b), .size_h_b(size_h_b),
		.done(done), .overlap(overlap), .pair_case(pair_case)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(overlap, pair_case);
	end

	function automatic spot_pkg::shape_t make_shape(logic [1:0] kind, logic signed [31:0] x,
			logic signed [31:0] y, logic [15:0] ang, logic [30:0] w, logic [30:0] h);
		spot_pkg::shape_t s;
		s.kind = kind; s.x = x; s.y = y; s.angle = ang; s.w = w; s.h = h;
		return s;
	endfunction

	// Mostly clustered shapes of modest size so that both verdicts are common.
	function automatic spot_pkg::shape_t random_shape(logic signed [31:0] cx,
			logic signed [31:0] cy);
		spot_pkg::shape_t s;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		s.kind = (sel == 0) ? spot_pkg::KIND_EMPTY : (sel == 1) ? KIND_UNUSED :
			(sel < 6) ? spot_pkg::KIND_RECT : spot_pkg::KIND_CIRCLE;
		s.angle = 16'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			s.x = $urandom;
			s.y = $urandom;
			s.w = 31'($urandom);
			s.h = 31'($urandom);
		end else begin
			s.x = cx + $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
			s.y = cy + $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
			s.w = 31'($urandom_range(0, 32'h000C_0000));
			s.h = 31'($urandom_range(0, 32'h000C_0000));
		end
		return s;
	endfunction

	task automatic send_pair(spot_pkg::shape_t a, spot_pkg::shape_t b, int gap);
		start <= 1'b1;
		kind_a <= a.kind; pos_x_a <= a.x; pos_y_a <= a.y; angle_a <= a.angle;
		size_w_a <= a.w; size_h_a <= a.h;
		kind_b <= b.kind; pos_x_b <= b.x; pos_y_b <= b.y; angle_b <= b.angle;
		size_w_b <= b.w; size_h_b <= b.h;
		do @(posedge clk); while (busy);
		board.note_transfer(a, b);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int random_gap(bit burst);
		int unsigned r;
		if (burst) return 0;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic wait_drained();
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		spot_pkg::shape_t a, b;
		logic signed [31:0] cx, cy;
		bit burst;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind_a = spot_pkg::KIND_EMPTY; pos_x_a = '0; pos_y_a = '0; angle_a = '0;
		size_w_a = '0; size_h_a = '0;
		kind_b = spot_pkg::KIND_EMPTY; pos_x_b = '0; pos_y_b = '0; angle_b = '0;
		size_w_b = '0; size_h_b = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs: every pair case, extremes, zero sizes, touching.
		send_pair(make_shape(spot_pkg::KIND_EMPTY, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF),
			make_shape(spot_pkg::KIND_RECT, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0);
		send_pair(make_shape(KIND_UNUSED, 0, 0, 0, 100, 100),
			make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 100, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 100, 0),
			make_shape(KIND_UNUSED, 0, 0, 0, 100, 0), 1);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 32'sh8000_0000, 32'sh8000_0000, 0,
				31'h7FFF_FFFF, 0),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF,
				31'h7FFF_FFFF, 31'h7FFF_FFFF), 0);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 31'h0003_0000, 0),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh0005_0000, 0, 0, 31'h0002_0000, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 31'h0003_0000, 0),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh0005_0001, 0, 0, 31'h0002_0000, 0), 2);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0),
			make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 0, 0, 0, 31'h0004_0000, 31'h0002_0000),
			make_shape(spot_pkg::KIND_RECT, 32'sh0004_0000, 0, 16'h4000,
				31'h0002_0000, 31'h0004_0000), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 0, 0, 16'h2000, 31'h0004_0000, 31'h0004_0000),
			make_shape(spot_pkg::KIND_RECT, 32'sh0005_0000, 32'sh0005_0000, 16'hA000,
				31'h0004_0000, 31'h0004_0000), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 0, 0, 16'h8000, 0, 0),
			make_shape(spot_pkg::KIND_RECT, 0, 0, 16'hC000, 0, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF,
				31'h7FFF_FFFF, 31'h7FFF_FFFF),
			make_shape(spot_pkg::KIND_RECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0001,
				31'h7FFF_FFFF, 31'h7FFF_FFFF), 3);
		send_pair(make_shape(spot_pkg::KIND_RECT, 0, 0, 0, 31'h0004_0000, 31'h0002_0000),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh0003_0000, 0, 0, 31'h0001_0000, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 32'sh0003_0000, 32'sh0002_0000, 0,
				31'h0001_0000, 0),
			make_shape(spot_pkg::KIND_RECT, 0, 0, 16'h4000, 31'h0004_0000, 31'h0002_0000), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 0, 0, 16'h6000, 31'h0002_0000, 31'h0002_0000),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh0002_0000, 32'sh0002_0000, 0,
				31'h0001_0000, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 32'sh8000_0000, 32'sh8000_0000, 16'h7FFF,
				31'h7FFF_FFFF, 31'h7FFF_FFFF),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0,
				31'h7FFF_FFFF, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_RECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'hC000, 0, 0),
			make_shape(spot_pkg::KIND_CIRCLE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0), 0);
		send_pair(make_shape(spot_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0),
			make_shape(spot_pkg::KIND_RECT, 0, 0, 0, 0, 0), 5);

		// Hold the input off until the pipeline has emptied once.
		start <= 1'b0;
		wait_drained();
		@(posedge clk);

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
			cx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
			cy = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
			a = random_shape(cx, cy);
			b = random_shape(cx, cy);
			send_pair(a, b, random_gap(burst));
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				wait_drained();
			end
		end
		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/spot_pkg.sv
design/spot_front.sv
design/spot_queue.sv
design/spot_back.sv
design/shape_pair_overlap_test.sv
sim/shape_pair_overlap_test_tb.sv
